>>> src/tssp_pkg.sv
// shared types and constants for the three-stack shared slot pool
// no dependencies
`default_nettype none

package tssp_pkg;

   localparam int SLOTS_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int NSTACKS        = 3;
   localparam int WORD_WIDTH     = 32;

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_BAD_STACK = 2'd3
   } status_type;

   typedef struct packed {
      op_type                        operation;
      logic [1:0]                    stack_select;
      logic signed [WORD_WIDTH-1:0]  push_value;
   } req_type;

   typedef struct packed {
      status_type                    status;
      logic signed [WORD_WIDTH-1:0]  pop_value;
   } rsp_type;

   // flags from the shared index step unit
   typedef struct packed {
      logic at_end;  // incremented index reached the empty marker
      logic below;   // first operand lies below the second
   } step_flags_type;

endpackage

`default_nettype wire

>>> src/tssp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module tssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/tssp_step.sv
// shared index step unit: increment with end check, and compare
// depends on tssp_pkg
`default_nettype none

module tssp_step #(
   parameter int SLOTS = tssp_pkg::SLOTS_DEF
) (
   input  wire logic [$clog2(SLOTS+1)-1:0] a_idx,
   input  wire logic [$clog2(SLOTS+1)-1:0] b_idx,
   output logic      [$clog2(SLOTS+1)-1:0] inc_idx,
   output tssp_pkg::step_flags_type        flags
);
   import tssp_pkg::*;

   localparam int IW = $clog2(SLOTS+1);
   localparam logic [IW-1:0] EMPTY_MARK = IW'(SLOTS);

   always_comb begin
      inc_idx      = a_idx + IW'(1);
      flags.at_end = (inc_idx == EMPTY_MARK);
      flags.below  = (a_idx < b_idx);
   end

endmodule

`default_nettype wire

>>> src/three_stacks_shared_pool_core.sv
// top level of the three-stack shared slot pool: sequencer, stack heads, result register
// depends on tssp_pkg, tssp_ram, tssp_step
//
// usage
//  - req channel (req_valid/req_ready/req_data) carries one word: operation, stack_select,
//    push_value. rsp channel (rsp_valid/rsp_ready/rsp_data) returns one word per request:
//    status and pop_value (zero unless a pop succeeded)
//  - all slots live in one ram word each (used mark, link, data); one read port serves both
//    the free-slot scan and the pop read
//  - order: bad stack number, pool full or empty stack go from idle straight to the done
//    state; a pop reads its slot first; a push fills the lowest free slot, then scans
//    upward for the next free slot unless it filled the last slot
//  - the free-slot scan walks the ram one slot per cycle through the shared step unit
//  - one request at a time; req_ready is high only while the sequencer is idle
//  - a finished result sits in the output register, so the next request is taken while
//    the receiver stalls; if the register is still full when the next result is ready,
//    the sequencer waits
//  - after reset a clearing pass zeroes the ram one slot at a time; req_ready stays low
//    meanwhile
`default_nettype none

module three_stacks_shared_pool_core #(
   parameter int SLOTS      = tssp_pkg::SLOTS_DEF,
   parameter int DATA_WIDTH = tssp_pkg::DATA_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire tssp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output tssp_pkg::rsp_type      rsp_data
);
   import tssp_pkg::*;

   localparam int AW = $clog2(SLOTS);        // slot address
   localparam int IW = $clog2(SLOTS+1);      // slot index incl. empty marker
   localparam int DW = DATA_WIDTH;
   localparam int RW = 1 + IW + DW;          // ram word: used, link, data
   localparam logic [IW-1:0] EMPTY_MARK = IW'(SLOTS);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_POP,
      S_DONE
   } state_type;

   // sequencer state
   state_type        state_ff,   state_in;
   logic [IW-1:0]    slot_ff,    slot_in;     // clear sweep, scan or pop slot
   logic [IW-1:0]    lfree_ff,   lfree_in;    // lowest free slot
   logic [IW-1:0]    head_ff [NSTACKS];
   logic [IW-1:0]    head_in [NSTACKS];
   logic [1:0]       sel_ff,     sel_in;
   rsp_type          res_ff,     res_in;      // result waiting for the output register
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff,  rsp_data_in;

   // ram ports
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [RW-1:0]    ram_wr_data;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [RW-1:0]    ram_rd_data;

   // step unit
   logic [IW-1:0]    step_a;
   logic [IW-1:0]    step_b;
   logic [IW-1:0]    step_inc;
   step_flags_type   step_flags;

   // read word fields
   logic             rd_used;
   logic [IW-1:0]    rd_link;
   logic [DW-1:0]    rd_value;

   logic [63:0]      push_ext;
   logic [DW-1:0]    push_store;
   logic [IW-1:0]    sel_head;

   // sign-extend a stored word from its top bit to the result width
   function automatic logic [WORD_WIDTH-1:0] widen_word(input logic [DW-1:0] d);
      logic [63:0]             ext;
      logic [WORD_WIDTH-1:0]   res;
      ext = 64'(d);
      for (int i = 0; i < WORD_WIDTH; i++) begin
         res[i] = (i < DW) ? ext[i] : ext[DW-1];
      end
      return res;
   endfunction

   tssp_ram #(
      .WIDTH (RW),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tssp_step #(
      .SLOTS (SLOTS)
   ) u_step (
      .a_idx   (step_a),
      .b_idx   (step_b),
      .inc_idx (step_inc),
      .flags   (step_flags)
   );

   assign rd_used    = ram_rd_data[RW-1];
   assign rd_link    = ram_rd_data[DW +: IW];
   assign rd_value   = ram_rd_data[DW-1:0];
   assign push_ext   = {32'b0, req_data.push_value};
   assign push_store = push_ext[DW-1:0];
   assign sel_head   = (req_data.stack_select < 2'(NSTACKS)) ?
                       head_ff[req_data.stack_select] : EMPTY_MARK;

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      lfree_in     = lfree_ff;
      head_in      = head_ff;
      sel_in       = sel_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = slot_ff[AW-1:0];
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = step_inc[AW-1:0];
      step_a       = slot_ff;
      step_b       = lfree_ff;

      case (state_ff)
         S_CLEAR: begin
            // zero one slot per cycle
            ram_wr_en = 1'b1;
            slot_in   = step_inc;
            if (step_flags.at_end) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               sel_in           = req_data.stack_select;
               res_in.status    = STATUS_OK;
               res_in.pop_value = '0;
               state_in         = S_DONE;
               if (req_data.stack_select >= 2'(NSTACKS)) begin
                  res_in.status = STATUS_BAD_STACK;
               end else if (req_data.operation == OP_PUSH) begin
                  if (lfree_ff == EMPTY_MARK) begin
                     res_in.status = STATUS_FULL;
                  end else begin
                     // fill lowest free slot, link to old head, start scan above it unless it is the last slot
                     step_a      = lfree_ff;
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = lfree_ff[AW-1:0];
                     ram_wr_data = {1'b1, sel_head, push_store};
                     head_in[req_data.stack_select] = lfree_ff;
                     if (step_flags.at_end) begin
                        lfree_in = EMPTY_MARK;
                     end else begin
                        ram_rd_en = 1'b1;
                        slot_in   = step_inc;
                        state_in  = S_SCAN;
                     end
                  end
               end else begin
                  if (sel_head == EMPTY_MARK) begin
                     res_in.status = STATUS_EMPTY;
                  end else begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = sel_head[AW-1:0];
                     slot_in     = sel_head;
                     state_in    = S_POP;
                  end
               end
            end
         end

         S_SCAN: begin
            // read data belongs to slot_ff
            if (!rd_used) begin
               lfree_in = slot_ff;
               state_in = S_DONE;
            end else if (step_flags.at_end) begin
               lfree_in = EMPTY_MARK;
               state_in = S_DONE;
            end else begin
               ram_rd_en = 1'b1;
               slot_in   = step_inc;
            end
         end

         S_POP: begin
            res_in.status    = STATUS_OK;
            res_in.pop_value = widen_word(rd_value);
            head_in[sel_ff]  = rd_link;
            ram_wr_en        = 1'b1;   // free the slot, word cleared
            if (step_flags.below) begin
               lfree_in = slot_ff;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         slot_ff      <= '0;
         lfree_ff     <= '0;
         for (int i = 0; i < NSTACKS; i++) begin
            head_ff[i] <= EMPTY_MARK;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         lfree_ff     <= lfree_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff      <= sel_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   // one request at a time: ready drops straight after an accepted word
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while sequencer busy");

   // a new result is only loaded from the done state
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid)) |-> $past(state_ff == S_DONE))
      else $error("result appeared outside the done state");

   // failed requests carry a zero data word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.pop_value == '0))
      else $error("non-zero data on a failed request");

   // indexes never pass the empty marker
   assert property (@(posedge clock) disable iff (reset)
      (lfree_ff <= EMPTY_MARK) && (head_ff[0] <= EMPTY_MARK) &&
      (head_ff[1] <= EMPTY_MARK) && (head_ff[2] <= EMPTY_MARK))
      else $error("slot index beyond the pool");
`endif

endmodule

`default_nettype wire
